### rtl/tagged_text_extractor_macros.svh
// Assertion helpers for the tagged text extractor.
// Define ASSERT_OFF to compile the checks away.
`ifndef TAGGED_TEXT_EXTRACTOR_MACROS_SVH
`define TAGGED_TEXT_EXTRACTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define TTE_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tagged_text_extractor: same-cycle check failed");

// Next-cycle implication.
`define TTE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tagged_text_extractor: next-cycle check failed");

`else

`define TTE_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TTE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

### rtl/tte_pkg.sv
`default_nettype none

package tte_pkg;

    localparam int MAX_WORD   = 32;
    localparam int MAX_MARKER = 12;

    localparam int WORD_AW   = $clog2(MAX_WORD);
    localparam int WLEN_W    = $clog2(MAX_WORD + 1);
    localparam int CMP_W     = WLEN_W + 1;
    localparam int TAG_LEN_W = 4;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 2'd2;

    localparam logic [63:0]          RST_CHARS_LOW  = 64'd112;
    localparam logic [31:0]          RST_CHARS_HIGH = 32'd0;
    localparam logic [TAG_LEN_W-1:0] RST_LENGTH     = 4'd1;

    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_LT    = 8'h3C;
    localparam logic [7:0] BYTE_GT    = 8'h3E;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;
    localparam logic [7:0] BYTE_HT    = 8'h09;
    localparam logic [7:0] BYTE_CR    = 8'h0D;

    // Tag name as seen by the word matcher; len already clamped to MAX_MARKER.
    typedef struct packed {
        logic [MAX_MARKER-1:0][7:0] chars;
        logic [TAG_LEN_W-1:0]       len;
    } tte_marker_t;

    // Word buffer write request.
    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        logic [7:0]         data;
    } tte_wr_t;

    // Word-end decision for the request just accepted.
    typedef struct packed {
        logic              fin;
        logic              is_open;
        logic              is_close;
        logic              ovf;
        logic [WLEN_W-1:0] len;
    } tte_word_ev_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == BYTE_SPACE) || ((b >= BYTE_HT) && (b <= BYTE_CR));
    endfunction

    function automatic logic [7:0] tag_char(input tte_marker_t m, input logic [CMP_W-1:0] i);
        if (i < CMP_W'(MAX_MARKER)) begin
            return m.chars[i[TAG_LEN_W-1:0]];
        end
        return 8'h00;
    endfunction

    // {hit_valid, byte} expected at position p of "<T>".
    function automatic logic [8:0] open_expect(input tte_marker_t m, input logic [WLEN_W-1:0] p);
        logic [CMP_W-1:0] pe;
        logic [CMP_W-1:0] le;
        pe = CMP_W'(p);
        le = CMP_W'(m.len);
        if (pe == '0) begin
            return {1'b1, BYTE_LT};
        end else if (pe <= le) begin
            return {1'b1, tag_char(m, pe - CMP_W'(1))};
        end else if (pe == le + CMP_W'(1)) begin
            return {1'b1, BYTE_GT};
        end
        return 9'h000;
    endfunction

    // {hit_valid, byte} expected at position p of "</T>".
    function automatic logic [8:0] close_expect(input tte_marker_t m, input logic [WLEN_W-1:0] p);
        logic [CMP_W-1:0] pe;
        logic [CMP_W-1:0] le;
        pe = CMP_W'(p);
        le = CMP_W'(m.len);
        if (pe == '0) begin
            return {1'b1, BYTE_LT};
        end else if (pe == CMP_W'(1)) begin
            return {1'b1, BYTE_SLASH};
        end else if (pe <= le + CMP_W'(1)) begin
            return {1'b1, tag_char(m, pe - CMP_W'(2))};
        end else if (pe == le + CMP_W'(2)) begin
            return {1'b1, BYTE_GT};
        end
        return 9'h000;
    endfunction

endpackage

`default_nettype wire

### rtl/tte_cfg.sv
`default_nettype none

module tte_cfg
    import tte_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    output tte_marker_t               marker
);

    logic [63:0]          chars_low_reg,  chars_low_next;
    logic [31:0]          chars_high_reg, chars_high_next;
    logic [TAG_LEN_W-1:0] length_reg,     length_next;

    always_comb begin
        chars_low_next  = chars_low_reg;
        chars_high_next = chars_high_reg;
        length_next     = length_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHARS_LOW:  chars_low_next  = cfg_wdata[63:0];
                CFG_CHARS_HIGH: chars_high_next = cfg_wdata[31:0];
                CFG_LENGTH:     length_next     = cfg_wdata[TAG_LEN_W-1:0];
                default:        ;   // unmapped index, ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_low_reg  <= RST_CHARS_LOW;
            chars_high_reg <= RST_CHARS_HIGH;
            length_reg     <= RST_LENGTH;
        end else begin
            chars_low_reg  <= chars_low_next;
            chars_high_reg <= chars_high_next;
            length_reg     <= length_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            marker.chars[i] = chars_low_reg[8*i +: 8];
        end
        for (int i = 8; i < MAX_MARKER; i++) begin
            marker.chars[i] = chars_high_reg[8*(i-8) +: 8];
        end
        // lengths beyond the tag slots count as a full tag
        if (length_reg > TAG_LEN_W'(MAX_MARKER)) begin
            marker.len = TAG_LEN_W'(MAX_MARKER);
        end else begin
            marker.len = length_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/tte_word_buf.sv
`default_nettype none

module tte_word_buf
    import tte_pkg::*;
(
    input  wire logic               aclk,
    input  wire tte_wr_t            wr,
    input  wire logic [WORD_AW-1:0] rd_addr,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [MAX_WORD];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/tte_word_scan.sv
`default_nettype none

module tte_word_scan
    import tte_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    input  wire tte_marker_t marker,
    output tte_wr_t          wr,
    output tte_word_ev_t     ev
);

    logic [WLEN_W-1:0] wlen_reg, wlen_next;
    logic              ovf_reg,  ovf_next;
    logic              om_reg,   om_next;
    logic              cm_reg,   cm_next;

    logic [WLEN_W-1:0] len_a;
    logic              ovf_a, om_a, cm_a, sp;
    logic [8:0]        oe, ce;

    always_comb begin
        sp    = is_space(text_byte);
        oe    = open_expect(marker, wlen_reg);
        ce    = close_expect(marker, wlen_reg);
        len_a = wlen_reg;
        ovf_a = ovf_reg;
        om_a  = om_reg;
        cm_a  = cm_reg;

        wr.en   = 1'b0;
        wr.addr = wlen_reg[WORD_AW-1:0];
        wr.data = text_byte;

        if (!sp) begin
            if (wlen_reg < WLEN_W'(MAX_WORD)) begin
                wr.en = accept;
                om_a  = om_reg && oe[8] && (oe[7:0] == text_byte);
                cm_a  = cm_reg && ce[8] && (ce[7:0] == text_byte);
                len_a = wlen_reg + WLEN_W'(1);
            end else begin
                // buffer full: keep the head, drop the rest
                ovf_a = 1'b1;
                om_a  = 1'b0;
                cm_a  = 1'b0;
            end
        end

        ev.fin      = (sp || end_of_text) && (len_a != '0);
        ev.ovf      = ovf_a;
        ev.len      = len_a;
        ev.is_open  = ev.fin && om_a && !ovf_a &&
                      (CMP_W'(len_a) == CMP_W'(marker.len) + CMP_W'(2));
        ev.is_close = ev.fin && cm_a && !ovf_a &&
                      (CMP_W'(len_a) == CMP_W'(marker.len) + CMP_W'(3));

        wlen_next = wlen_reg;
        ovf_next  = ovf_reg;
        om_next   = om_reg;
        cm_next   = cm_reg;
        if (accept) begin
            if (ev.fin || end_of_text) begin
                wlen_next = '0;
                ovf_next  = 1'b0;
                om_next   = 1'b1;
                cm_next   = 1'b1;
            end else begin
                wlen_next = len_a;
                ovf_next  = ovf_a;
                om_next   = om_a;
                cm_next   = cm_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= '0;
            ovf_reg  <= 1'b0;
            om_reg   <= 1'b1;
            cm_reg   <= 1'b1;
        end else begin
            wlen_reg <= wlen_next;
            ovf_reg  <= ovf_next;
            om_reg   <= om_next;
            cm_reg   <= cm_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tagged_text_extractor.sv
// A byte inside a word is absorbed and causes no result.
// At a word end the leading space is loaded into the m_* output register first, then each word
// byte in turn once its buffer read is fresh (buffer read plus address step).
// Requests: s_tready is low while a word or a sentence end is emitted, so no new request
// is taken until all results of the last one are loaded; m_tready stalls hold it longer.
// Reset: synchronous, active-low aresetn; tag returns to "p", word buffer not cleared.
`default_nettype none

`include "tagged_text_extractor_macros.svh"

module tagged_text_extractor
    import tte_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] text_byte
    input  wire logic                 s_tlast,   // end_of_text

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [7:0] out_byte
    output logic [1:0]                m_tuser,   // [0] kind, [1] word_truncated
    output logic                      m_tlast    // last_of_run
);

    // Emit sequencer. IDLE takes requests; the others drain results of one request.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SPACE = 4'b0010,
        S_BYTES = 4'b0100,
        S_EOS   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    tte_marker_t  marker;
    tte_wr_t      wr;
    tte_word_ev_t ev;
    logic [7:0]   rd_data;

    logic              accept;
    logic              recording_reg, recording_next;
    logic              has_text_reg,  has_text_next;
    logic              eos_pend_reg,  eos_pend_next;
    logic              trunc_reg,     trunc_next;
    logic [WLEN_W-1:0] rep_len_reg,   rep_len_next;
    logic [WLEN_W-1:0] rd_idx_reg,    rd_idx_next;
    logic [WLEN_W-1:0] idx_inc;
    logic              fresh_reg,     fresh_next;

    logic              words, rec_after, has_after, eos, last_byte;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_trunc_reg, out_last_reg;
    logic [7:0]        out_byte_reg;
    logic              out_free, out_load;
    logic              ld_kind, ld_trunc, ld_last;
    logic [7:0]        ld_byte;

    tte_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .marker    (marker)
    );

    tte_word_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .marker      (marker),
        .wr          (wr),
        .ev          (ev)
    );

    tte_word_buf u_buf (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_idx_reg[WORD_AW-1:0]),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign idx_inc  = rd_idx_reg + WLEN_W'(1);
    assign last_byte = (idx_inc == rep_len_reg);

    // Word-end decisions for the request being taken.
    always_comb begin
        words     = ev.fin && !ev.is_open && !ev.is_close && recording_reg;
        rec_after = ev.is_open ? 1'b1 : (ev.is_close ? 1'b0 : recording_reg);
        has_after = ev.is_close ? 1'b0 : (words ? 1'b1 : has_text_reg);
        // close marker always ends a sentence; end of text only if it has text
        eos       = ev.is_close || (s_tlast && has_after);
    end

    always_comb begin
        state_next     = state_reg;
        recording_next = recording_reg;
        has_text_next  = has_text_reg;
        eos_pend_next  = eos_pend_reg;
        trunc_next     = trunc_reg;
        rep_len_next   = rep_len_reg;
        rd_idx_next    = rd_idx_reg;

        out_load = 1'b0;
        ld_kind  = 1'b0;
        ld_byte  = BYTE_SPACE;
        ld_trunc = trunc_reg;
        ld_last  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    recording_next = s_tlast ? 1'b0 : rec_after;
                    has_text_next  = s_tlast ? 1'b0 : has_after;
                    if (words) begin
                        rep_len_next  = ev.len;
                        trunc_next    = ev.ovf;
                        eos_pend_next = eos;
                        rd_idx_next   = '0;
                        state_next    = S_SPACE;
                    end else if (eos) begin
                        state_next    = S_EOS;
                    end
                end
            end
            S_SPACE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_BYTES;
                end
            end
            S_BYTES: begin
                // wait until read data matches the current index
                if (out_free && fresh_reg) begin
                    out_load    = 1'b1;
                    ld_byte     = rd_data;
                    ld_last     = last_byte && !eos_pend_reg;
                    rd_idx_next = idx_inc;
                    if (last_byte) begin
                        state_next = eos_pend_reg ? S_EOS : S_IDLE;
                    end
                end
            end
            S_EOS: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ld_kind    = 1'b1;
                    ld_byte    = 8'h00;
                    ld_trunc   = 1'b0;
                    ld_last    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // a request may write the buffer, so its read data is stale next cycle
        fresh_next = (rd_idx_next == rd_idx_reg) && !accept;

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            recording_reg <= 1'b0;
            has_text_reg  <= 1'b0;
            eos_pend_reg  <= 1'b0;
            rd_idx_reg    <= '0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            recording_reg <= recording_next;
            has_text_reg  <= has_text_next;
            eos_pend_reg  <= eos_pend_next;
            rd_idx_reg    <= rd_idx_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        trunc_reg   <= trunc_next;
        rep_len_reg <= rep_len_next;
        if (out_load) begin
            out_kind_reg  <= ld_kind;
            out_byte_reg  <= ld_byte;
            out_trunc_reg <= ld_trunc;
            out_last_reg  <= ld_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_trunc_reg, out_kind_reg};
    assign m_tlast  = out_last_reg;

    // end of sentence carries a zero byte and no truncation flag
    `TTE_ASSERT_IMPL(a_eos_payload, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata == 8'h00) && !m_tuser[1])
    // end of sentence is always the final result of its request
    `TTE_ASSERT_IMPL(a_eos_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast)
    // replay index stays inside the captured word
    `TTE_ASSERT_IMPL(a_idx_range, aclk, aresetn, state_reg == S_BYTES, rd_idx_reg < rep_len_reg)
    // end of text drops recording and sentence state
    `TTE_ASSERT_NEXT(a_eot_clear, aclk, aresetn, accept && s_tlast, !recording_reg && !has_text_reg)

endmodule

`default_nettype wire

### verif/tagged_text_extractor_tb.sv
`timescale 1ns / 1ps

module tagged_text_extractor_tb
    import tte_pkg::*;
();

    localparam int CLK_PERIOD = 20;

    // Register index with no register behind it: the write must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Result kinds and m_tuser bit positions.
    localparam bit KIND_TEXT = 1'b0;
    localparam bit KIND_EOS  = 1'b1;
    localparam int USER_KIND  = 0;
    localparam int USER_TRUNC = 1;

    // One request for the input side. drain: hold it back until every
    // expected result has been seen.
    typedef struct {
        logic [7:0] data;
        bit         eot;
        bit         drain;
    } text_req_t;

    // One expected result.
    typedef struct {
        bit         kind;
        logic [7:0] data;
        bit         trunc;
        bit         last;
    } text_res_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // [7:0] text_byte
    logic                 s_tlast   = 1'b0; // end_of_text
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // [7:0] out_byte
    logic [1:0]           m_tuser;          // [0] kind, [1] word_truncated
    logic                 m_tlast;          // last_of_run

    tagged_text_extractor i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    text_req_t pending_req[$];
    text_res_t expected_res[$];
    int        n_queued   = 0;
    int        n_accepted = 0;
    int        n_errors   = 0;
    bit        steady_flow = 1'b0;  // no sender gaps, no receiver stalls

    // ------------------------------------------------------------------
    // Predictor: tag registers and word/sentence state, kept in step with
    // the block. Updated on every accepted request.
    // ------------------------------------------------------------------
    logic [63:0] tag_lo;
    logic [31:0] tag_hi;
    logic [3:0]  tag_len_q;

    logic [7:0]  word_buf [MAX_WORD];
    int          word_fill;
    bit          word_cut;
    bit          open_ok;
    bit          close_ok;
    bit          capturing;
    bit          sentence_text;

    function automatic bit is_blank(logic [7:0] b);
        return b == BYTE_SPACE || (b >= BYTE_HT && b <= BYTE_CR);
    endfunction

    // Lengths above MAX_MARKER clamp.
    function automatic int tag_span();
        return (int'(tag_len_q) > MAX_MARKER) ? MAX_MARKER : int'(tag_len_q);
    endfunction

    function automatic int tag_at(int i);
        if (i < 8)
            return int'(tag_lo[8*i +: 8]);
        if (i < 12)
            return int'(tag_hi[8*(i-8) +: 8]);
        return -1;
    endfunction

    // Byte wanted at position p of "<T>" / "</T>"; -1 past the end.
    function automatic int open_byte_at(int p);
        int span;
        span = tag_span();
        if (p == 0) return int'(BYTE_LT);
        if (p <= span) return tag_at(p - 1);
        if (p == span + 1) return int'(BYTE_GT);
        return -1;
    endfunction

    function automatic int close_byte_at(int p);
        int span;
        span = tag_span();
        if (p == 0) return int'(BYTE_LT);
        if (p == 1) return int'(BYTE_SLASH);
        if (p <= span + 1) return tag_at(p - 2);
        if (p == span + 2) return int'(BYTE_GT);
        return -1;
    endfunction

    function automatic void clear_word();
        word_fill = 0;
        word_cut  = 1'b0;
        open_ok   = 1'b1;
        close_ok  = 1'b1;
    endfunction

    function automatic void put_result(bit kind, logic [7:0] data, bit trunc);
        text_res_t r;
        r.kind  = kind;
        r.data  = data;
        r.trunc = trunc;
        r.last  = 1'b0;
        expected_res = {expected_res, r};
    endfunction

    function automatic void add_byte(logic [7:0] b);
        if (word_fill < MAX_WORD) begin
            word_buf[word_fill] = b;
            if (open_byte_at(word_fill) != int'(b)) open_ok = 1'b0;
            if (close_byte_at(word_fill) != int'(b)) close_ok = 1'b0;
            word_fill++;
        end else begin
            // Overlong word: cut, flagged, never a marker.
            word_cut = 1'b1;
            open_ok  = 1'b0;
            close_ok = 1'b0;
        end
    endfunction

    function automatic void end_word();
        int span;
        span = tag_span();
        if (open_ok && !word_cut && word_fill == span + 2) begin
            capturing = 1'b1;
        end else if (close_ok && !word_cut && word_fill == span + 3) begin
            // Close marker emits end of sentence even when nothing was captured.
            capturing = 1'b0;
            put_result(KIND_EOS, 8'h00, 1'b0);
            sentence_text = 1'b0;
        end else if (capturing) begin
            put_result(KIND_TEXT, BYTE_SPACE, word_cut);
            for (int i = 0; i < word_fill; i++)
                put_result(KIND_TEXT, word_buf[i], word_cut);
            sentence_text = 1'b1;
        end
        clear_word();
    endfunction

    function automatic void predict_extract(logic [7:0] b, bit eot);
        int first;
        first = expected_res.size();
        if (is_blank(b)) begin
            if (word_fill > 0) end_word();
        end else begin
            add_byte(b);
        end
        // End of text: flush the word, close a sentence holding text, back to idle.
        if (eot) begin
            if (word_fill > 0) end_word();
            if (sentence_text) put_result(KIND_EOS, 8'h00, 1'b0);
            clear_word();
            capturing     = 1'b0;
            sentence_text = 1'b0;
        end
        if (expected_res.size() > first)
            expected_res[expected_res.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued requests in bursts with random gaps.
    // ------------------------------------------------------------------
    int        burst_left = 0;
    int        gap_left   = 0;
    text_req_t next_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_extract(s_tdata, s_tlast);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_req.size() > 0 &&
                             !(pending_req[0].drain && expected_res.size() != 0)) begin
                    next_req = pending_req.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.data;
                    s_tlast  <= next_req.eot;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if (!steady_flow) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: ready runs and stall runs of random length; every result
    // is checked against the oldest expectation.
    // ------------------------------------------------------------------
    bit        rx_on   = 1'b1;
    int        rx_left = 0;
    text_res_t want;

    task automatic report_mismatch(string what);
        $display("%0t ns: %s", $time, what);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data=%02h user=%b last=%b",
                                              m_tdata, m_tuser, m_tlast));
                end else begin
                    want = expected_res.pop_front();
                    if (m_tuser[USER_KIND] !== want.kind || m_tdata !== want.data ||
                        m_tuser[USER_TRUNC] !== want.trunc || m_tlast !== want.last)
                        report_mismatch($sformatf(
                            "result kind/data/trunc/last got %b/%02h/%b/%b want %b/%02h/%b/%b",
                            m_tuser[USER_KIND], m_tdata, m_tuser[USER_TRUNC], m_tlast,
                            want.kind, want.data, want.trunc, want.last));
                end
            end
            if (rx_left > 0) begin
                rx_left--;
            end else begin
                rx_on   = !rx_on;
                rx_left = rx_on ? $urandom_range(0, 20) :
                          (($urandom_range(0, 7) == 0) ? $urandom_range(4, 12)
                                                       : $urandom_range(0, 2));
            end
            m_tready <= rx_on || steady_flow;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_item(logic [7:0] b, bit eot, bit drain);
        text_req_t r;
        r.data  = b;
        r.eot   = eot;
        r.drain = drain;
        pending_req = {pending_req, r};
        n_queued++;
    endfunction

    function automatic void push_str(string s, bit drain_first);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0, drain_first && i == 0);
    endfunction

    function automatic logic [7:0] ink_byte(bit printable);
        logic [7:0] b;
        if (printable)
            return 8'($urandom_range(8'h21, 8'h7E));
        do b = 8'($urandom_range(0, 255)); while (is_blank(b));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? BYTE_SPACE : BYTE_HT + 8'(r);
    endfunction

    function automatic logic [63:0] inked64(bit printable);
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = ink_byte(printable);
        return w;
    endfunction

    function automatic void push_blanks();
        repeat ($urandom_range(1, 2)) push_item(blank_byte(), 1'b0, 1'b0);
    endfunction

    // Mostly short words; now and then one around or past the buffer size.
    function automatic void push_word(bit ends_doc);
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(29, 40) : $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
            push_item(ink_byte(1'b0), ends_doc && i == n - 1, 1'b0);
    endfunction

    // Marker for the current tag. flaw: 0 intact, 1 one byte altered,
    // 2 closing '>' missing, 3 extra byte before '>', 4 long tail appended.
    function automatic void push_marker(bit closing, int flaw);
        logic [7:0] mk[$];
        int         idx;
        bit         drain;
        mk = {mk, BYTE_LT};
        if (closing) mk = {mk, BYTE_SLASH};
        for (int i = 0; i < tag_span(); i++)
            mk = {mk, 8'(tag_at(i))};
        mk = {mk, BYTE_GT};
        unique case (flaw)
            1: begin
                idx = $urandom_range(0, mk.size() - 1);
                mk[idx] = mk[idx] ^ 8'($urandom_range(1, 255));
            end
            2: mk.pop_back();
            3: mk.insert(mk.size() - 1, ink_byte(1'b0));
            4: repeat ($urandom_range(20, 34)) mk = {mk, ink_byte(1'b0)};
            default: ;
        endcase
        drain = !closing && flaw == 0 && $urandom_range(0, 19) == 0;
        for (int i = 0; i < mk.size(); i++)
            push_item(mk[i], 1'b0, drain && i == 0);
    endfunction

    // Random text: mostly well-formed sentences, the rest broken markers,
    // stray markers, raw noise and document ends.
    function automatic void gen_text(int budget);
        int stop_at;
        int pick;
        stop_at = n_queued + budget;
        while (n_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                push_marker(1'b0, 0);
                push_blanks();
                repeat ($urandom_range(0, 4)) begin
                    push_word(1'b0);
                    push_blanks();
                end
                if ($urandom_range(0, 9) == 0) begin
                    push_word(1'b1);    // text ends inside the sentence
                end else begin
                    push_marker(1'b1, 0);
                    push_blanks();
                end
            end else if (pick < 74) begin
                push_marker(1'($urandom_range(0, 1)), $urandom_range(1, 4));
                push_blanks();
            end else if (pick < 82) begin
                // stray close, or an open that may come while already capturing
                push_marker(1'($urandom_range(0, 1)), 0);
                push_blanks();
            end else if (pick < 94) begin
                repeat ($urandom_range(1, 6)) push_item(8'($urandom), 1'b0, 1'b0);
            end else begin
                push_item(8'($urandom), 1'b1, 1'b0);
            end
        end
    endfunction

    // Register write; the block samples it at the next rising edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        unique case (idx)
            CFG_CHARS_LOW:  tag_lo    = val;
            CFG_CHARS_HIGH: tag_hi    = val[31:0];
            CFG_LENGTH:     tag_len_q = val[3:0];
            default: ;
        endcase
    endtask

    // Unused upper write bits carry junk; the block must ignore them.
    task automatic set_tag(logic [63:0] lo, logic [31:0] hi, logic [3:0] span);
        write_reg(CFG_CHARS_LOW, lo);
        write_reg(CFG_CHARS_HIGH, {$urandom, hi});
        write_reg(CFG_LENGTH, {$urandom, 28'($urandom), span});
    endtask

    // All requests taken and all results seen, then a settle time so a
    // word byte still being absorbed is done before the next write.
    task automatic wait_idle(int settle);
        while (n_accepted != n_queued || expected_res.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        tag_lo    = RST_CHARS_LOW;
        tag_hi    = RST_CHARS_HIGH;
        tag_len_q = RST_LENGTH;
        clear_word();
        capturing     = 1'b0;
        sentence_text = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset tag "p".
        push_str("<p>", 1'b0);
        push_item(BYTE_SPACE, 1'b0, 1'b0);
        push_item(8'hFF, 1'b0, 1'b0);           // extreme and odd bytes inside a word
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h80, 1'b0, 1'b0);
        push_item(8'h0D, 1'b0, 1'b0);
        push_str("<p>", 1'b1);                  // open while capturing, after a full drain
        push_item(8'h09, 1'b0, 1'b0);
        push_str("</p>", 1'b0);
        push_item(8'h0A, 1'b0, 1'b0);
        push_item(BYTE_SPACE, 1'b0, 1'b0);      // blank with no word pending
        push_str("</p>", 1'b0);                 // close while not capturing
        push_item(8'h0C, 1'b0, 1'b0);
        push_str("<p>", 1'b0);
        push_item(8'h0B, 1'b0, 1'b0);
        push_item(8'h7F, 1'b0, 1'b0);
        push_item(8'h08, 1'b0, 1'b0);           // just outside the blank range
        push_item(8'h0E, 1'b1, 1'b0);           // text ends on a word byte
        wait_idle(20);

        for (int ph = 0; ph < 6; ph++) begin
            steady_flow = (ph == 1);
            unique case (ph)
                0: set_tag(inked64(1'b0), 32'(inked64(1'b0)), 4'd12);  // longest tag
                1: set_tag(inked64(1'b0), 32'(inked64(1'b0)), 4'd0);   // "<>" and "</>"
                2: set_tag(inked64(1'b0), 32'(inked64(1'b0)), 4'd15);  // clamps to 12
                3: begin
                    set_tag('1, '1, 4'd3);
                    write_reg(CFG_UNUSED, {$urandom, $urandom});
                end
                4: set_tag('0, '0, 4'd1);
                default: set_tag(inked64(1'b1), 32'(inked64(1'b1)),
                                 4'($urandom_range(1, 11)));
            endcase
            cfg_we <= 1'b0;
            gen_text(40);
            wait_idle(20);
        end

        wait_idle(80);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/tte_pkg.sv
rtl/tte_cfg.sv
rtl/tte_word_buf.sv
rtl/tte_word_scan.sv
rtl/tagged_text_extractor.sv
verif/tagged_text_extractor_tb.sv
